// ===== src/swmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants for the sliding-window multiset match block.
// ----------------------------------------------------------------------------
package swmm_pkg;

    localparam int CNT_BITS       = 9;
    localparam int CFG_BITS       = 9;
    localparam int CFG_INDEX_BITS = 2;
    localparam int HITS_BITS      = 32;

    // reference counts stick at this value
    localparam logic [CNT_BITS-1:0] REF_LIMIT = 9'd511;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MATCH_THRESHOLD = 2'd1;

    localparam logic [CFG_BITS-1:0] WINDOW_LENGTH_RESET   = 9'd1;
    localparam logic [CFG_BITS-1:0] MATCH_THRESHOLD_RESET = 9'd1;

    localparam logic ACT_REFERENCE = 1'b0;
    localparam logic ACT_STREAM    = 1'b1;

    typedef struct packed {
        logic [CNT_BITS-1:0]  match_count;
        logic                 window_full;
        logic                 window_hit;
        logic [HITS_BITS-1:0] hits_total;
    } result_t;

endpackage

// ===== src/sliding_window_multiset_match_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_multiset_match_top
// Sliding-window multiset intersection counter with reference histogram.
// ----------------------------------------------------------------------------
// A new word waits while the previous one is in p1; results go through p1 and
// p2 into a 2-word output buffer, so input flows while one result waits.
// The spacing comes from the single histogram read port and the window
// histogram's single write port: each stream value updates two entries (the
// evicted value and the new one). After reset both histograms are zeroed,
// one entry per cycle, over 2**VALUE_BITS entries (1024 at the default);
// s_ready stays low during the sweep while cfg writes are taken as usual.
// ----------------------------------------------------------------------------
module sliding_window_multiset_match_top
    import swmm_pkg::*;
#(
    parameter int VALUE_BITS = 10,
    parameter int WINDOW_MAX = 256
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic [VALUE_BITS-1:0]     s_value,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [CNT_BITS-1:0]       m_match_count,
    output logic                      m_window_full,
    output logic                      m_window_hit,
    output logic [HITS_BITS-1:0]      m_hits_total,

    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    localparam int VALUE_COUNT = 1 << VALUE_BITS;
    localparam int PTR_BITS    = $clog2(WINDOW_MAX);
    localparam int FILL_BITS   = $clog2(WINDOW_MAX + 1);
    localparam int LEN_BITS    = (FILL_BITS > CFG_BITS) ? FILL_BITS : CFG_BITS;
    localparam int IDX_BITS    = FILL_BITS + 1;

    localparam logic [LEN_BITS-1:0] WM_LEN   = LEN_BITS'(WINDOW_MAX);
    localparam logic [IDX_BITS-1:0] WM_IDX   = IDX_BITS'(WINDOW_MAX);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(WINDOW_MAX - 1);

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    logic [CNT_BITS-1:0]   ref_mem  [VALUE_COUNT];
    logic [CNT_BITS-1:0]   win_mem  [VALUE_COUNT];
    logic [VALUE_BITS-1:0] ring_mem [WINDOW_MAX];

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    logic [CFG_BITS-1:0]   window_length_reg;
    logic [CFG_BITS-1:0]   match_threshold_reg;
    logic                  clr_busy_reg;
    logic [VALUE_BITS-1:0] clr_addr_reg;
    logic [PTR_BITS-1:0]   ptr_reg, ptr_next;
    logic [FILL_BITS-1:0]  fill_reg, fill_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [HITS_BITS-1:0]  hits_reg, hits_next;
    logic                  p1_valid_reg;
    logic                  p2_valid_reg;
    logic                  pend_valid_reg;
    logic                  fw_ref_valid_reg;
    logic                  fw_win0_valid_reg;
    logic                  fw_win1_valid_reg;
    logic                  out_wr_ptr_reg;
    logic                  out_rd_ptr_reg;
    logic [1:0]            out_cnt_reg;

    // ------------------------------------------------------------------
    // payload state
    // ------------------------------------------------------------------
    logic                  p1_action_reg, p2_action_reg;
    logic [VALUE_BITS-1:0] p1_value_reg, p2_value_reg;
    logic                  p1_evict_reg, p2_evict_reg;
    logic                  p1_full_reg, p2_full_reg;
    logic [VALUE_BITS-1:0] ring_rd_reg;
    logic [CNT_BITS-1:0]   hist_ref_rd_reg, hist_win_rd_reg;
    logic [CNT_BITS-1:0]   va_ref_reg, va_win_reg;
    logic [VALUE_BITS-1:0] pend_addr_reg;
    logic [CNT_BITS-1:0]   pend_data_reg;
    logic [VALUE_BITS-1:0] fw_ref_addr_reg, fw_win0_addr_reg, fw_win1_addr_reg;
    logic [CNT_BITS-1:0]   fw_ref_data_reg, fw_win0_data_reg, fw_win1_data_reg;
    result_t               out_buf_reg [2];

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic s_accept;
    logic m_pop;

    // one slot must stay free for every word still in flight
    assign s_ready  = !clr_busy_reg && !p1_valid_reg
                      && ((out_cnt_reg + {1'b0, p2_valid_reg}) < 2'd2);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = (out_cnt_reg != 2'd0);
    assign m_pop    = m_valid && m_ready;

    assign m_match_count = out_buf_reg[out_rd_ptr_reg].match_count;
    assign m_window_full = out_buf_reg[out_rd_ptr_reg].window_full;
    assign m_window_hit  = out_buf_reg[out_rd_ptr_reg].window_hit;
    assign m_hits_total  = out_buf_reg[out_rd_ptr_reg].hits_total;

    // ------------------------------------------------------------------
    // accept stage: window bookkeeping and ring access
    // ------------------------------------------------------------------
    logic [LEN_BITS-1:0]  wl_ext, eff_len;
    logic                 is_stream, evict_now, full_now;
    logic [FILL_BITS-1:0] fill_after;
    logic [IDX_BITS-1:0]  idx_sum, idx_wrap;
    logic [PTR_BITS-1:0]  evict_addr;

    always_comb begin
        wl_ext = LEN_BITS'(window_length_reg);
        if (wl_ext == '0) begin
            eff_len = LEN_BITS'(1);
        end else if (wl_ext > WM_LEN) begin
            eff_len = WM_LEN;
        end else begin
            eff_len = wl_ext;
        end

        is_stream  = (s_action == ACT_STREAM);
        evict_now  = is_stream && (LEN_BITS'(fill_reg) >= eff_len);
        fill_after = (is_stream && !evict_now) ? fill_reg + FILL_BITS'(1) : fill_reg;
        full_now   = (LEN_BITS'(fill_after) >= eff_len);

        // oldest entry sits fill_reg slots behind the write pointer
        idx_sum    = IDX_BITS'(ptr_reg) + WM_IDX - IDX_BITS'(fill_reg);
        idx_wrap   = (idx_sum >= WM_IDX) ? idx_sum - WM_IDX : idx_sum;
        evict_addr = idx_wrap[PTR_BITS-1:0];

        ptr_next  = ptr_reg;
        fill_next = fill_reg;
        if (s_accept && is_stream) begin
            ptr_next  = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_BITS'(1);
            fill_next = fill_after;
        end
    end

    // read-first: a full ring reads the oldest value before it is replaced
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ring_rd_reg <= ring_mem[evict_addr];
            if (is_stream) begin
                ring_mem[ptr_reg] <= s_value;
            end
        end
    end

    // ------------------------------------------------------------------
    // compute stage (p2): forwarded reads, count update, write-back
    // ------------------------------------------------------------------
    logic [CNT_BITS-1:0]   ra, wa, rb, wb, wb_dec, wv, wv_new, c1, c2;
    logic                  do_evict, same_value;
    logic                  ref_we, win_we, hit_now;
    logic [VALUE_BITS-1:0] ref_waddr, win_waddr, hist_rd_addr;
    logic [CNT_BITS-1:0]   ref_wdata, win_wdata;
    logic                  ev_wr;
    result_t               res_now;

    always_comb begin
        // previous word's writes may have missed our reads
        ra = va_ref_reg;
        if (fw_ref_valid_reg && fw_ref_addr_reg == p2_value_reg) ra = fw_ref_data_reg;
        rb = hist_ref_rd_reg;
        if (fw_ref_valid_reg && fw_ref_addr_reg == ring_rd_reg) rb = fw_ref_data_reg;
        wa = va_win_reg;
        if (fw_win0_valid_reg && fw_win0_addr_reg == p2_value_reg) wa = fw_win0_data_reg;
        if (fw_win1_valid_reg && fw_win1_addr_reg == p2_value_reg) wa = fw_win1_data_reg;
        wb = hist_win_rd_reg;
        if (fw_win0_valid_reg && fw_win0_addr_reg == ring_rd_reg) wb = fw_win0_data_reg;
        if (fw_win1_valid_reg && fw_win1_addr_reg == ring_rd_reg) wb = fw_win1_data_reg;

        same_value = (ring_rd_reg == p2_value_reg);
        do_evict   = p2_evict_reg && (wb != '0);
        wb_dec     = wb - CNT_BITS'(1);
        c1         = (do_evict && rb > wb_dec && count_reg != '0)
                     ? count_reg - CNT_BITS'(1) : count_reg;
        wv         = (do_evict && same_value) ? wb_dec : wa;
        wv_new     = wv + CNT_BITS'(1);
        c2         = (ra >= wv_new) ? c1 + CNT_BITS'(1) : c1;
        ev_wr      = do_evict && !same_value;

        count_next = count_reg;
        hits_next  = hits_reg;
        hit_now    = 1'b0;
        if (p2_valid_reg) begin
            if (p2_action_reg == ACT_STREAM) begin
                count_next = c2;
                if (p2_full_reg && c2 >= match_threshold_reg) begin
                    hit_now = 1'b1;
                    if (hits_reg != '1) hits_next = hits_reg + HITS_BITS'(1);
                end
            end else if (ra < REF_LIMIT && wa > ra) begin
                count_next = count_reg + CNT_BITS'(1);
            end
        end

        res_now.match_count = count_next;
        res_now.window_full = p2_full_reg;
        res_now.window_hit  = hit_now;
        res_now.hits_total  = hits_next;

        // write ports: clearing sweep, then compute stage, then deferred evict
        ref_we    = 1'b0;
        ref_waddr = p2_value_reg;
        ref_wdata = ra + CNT_BITS'(1);
        win_we    = 1'b0;
        win_waddr = p2_value_reg;
        win_wdata = wv_new;
        if (clr_busy_reg) begin
            ref_we    = 1'b1;
            ref_waddr = clr_addr_reg;
            ref_wdata = '0;
            win_we    = 1'b1;
            win_waddr = clr_addr_reg;
            win_wdata = '0;
        end else begin
            ref_we = p2_valid_reg && (p2_action_reg == ACT_REFERENCE) && (ra < REF_LIMIT);
            if (p2_valid_reg && p2_action_reg == ACT_STREAM) begin
                win_we = 1'b1;
            end else if (pend_valid_reg) begin
                win_we    = 1'b1;
                win_waddr = pend_addr_reg;
                win_wdata = pend_data_reg;
            end
        end

        hist_rd_addr = p1_valid_reg ? ring_rd_reg : s_value;
    end

    // single read port: new value on accept, evicted value in the following cycle
    always_ff @(posedge aclk) begin
        if (s_accept || p1_valid_reg) begin
            hist_ref_rd_reg <= ref_mem[hist_rd_addr];
            hist_win_rd_reg <= win_mem[hist_rd_addr];
        end
        if (ref_we) begin
            ref_mem[ref_waddr] <= ref_wdata;
        end
        if (win_we) begin
            win_mem[win_waddr] <= win_wdata;
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_action_reg <= s_action;
            p1_value_reg  <= s_value;
            p1_evict_reg  <= evict_now;
            p1_full_reg   <= full_now;
        end
        if (p1_valid_reg) begin
            p2_action_reg <= p1_action_reg;
            p2_value_reg  <= p1_value_reg;
            p2_evict_reg  <= p1_evict_reg;
            p2_full_reg   <= p1_full_reg;
            va_ref_reg    <= hist_ref_rd_reg;
            va_win_reg    <= hist_win_rd_reg;
        end
        if (p2_valid_reg) begin
            pend_addr_reg    <= ring_rd_reg;
            pend_data_reg    <= wb_dec;
            fw_ref_addr_reg  <= p2_value_reg;
            fw_ref_data_reg  <= ra + CNT_BITS'(1);
            fw_win0_addr_reg <= p2_value_reg;
            fw_win0_data_reg <= wv_new;
            fw_win1_addr_reg <= ring_rd_reg;
            fw_win1_data_reg <= wb_dec;
            out_buf_reg[out_wr_ptr_reg] <= res_now;
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg   <= WINDOW_LENGTH_RESET;
            match_threshold_reg <= MATCH_THRESHOLD_RESET;
            clr_busy_reg        <= 1'b1;
            clr_addr_reg        <= '0;
            ptr_reg             <= '0;
            fill_reg            <= '0;
            count_reg           <= '0;
            hits_reg            <= '0;
            p1_valid_reg        <= 1'b0;
            p2_valid_reg        <= 1'b0;
            pend_valid_reg      <= 1'b0;
            fw_ref_valid_reg    <= 1'b0;
            fw_win0_valid_reg   <= 1'b0;
            fw_win1_valid_reg   <= 1'b0;
            out_wr_ptr_reg      <= 1'b0;
            out_rd_ptr_reg      <= 1'b0;
            out_cnt_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_WINDOW_LENGTH:   window_length_reg   <= cfg_data;
                    REG_MATCH_THRESHOLD: match_threshold_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + VALUE_BITS'(1);
                if (clr_addr_reg == '1) clr_busy_reg <= 1'b0;
            end

            ptr_reg      <= ptr_next;
            fill_reg     <= fill_next;
            count_reg    <= count_next;
            hits_reg     <= hits_next;
            p1_valid_reg <= s_accept;
            p2_valid_reg <= p1_valid_reg;

            if (p2_valid_reg) begin
                pend_valid_reg    <= (p2_action_reg == ACT_STREAM) && ev_wr;
                fw_ref_valid_reg  <= ref_we;
                fw_win0_valid_reg <= (p2_action_reg == ACT_STREAM);
                fw_win1_valid_reg <= (p2_action_reg == ACT_STREAM) && ev_wr;
            end else begin
                pend_valid_reg <= 1'b0;
            end

            if (p2_valid_reg) out_wr_ptr_reg <= !out_wr_ptr_reg;
            if (m_pop)        out_rd_ptr_reg <= !out_rd_ptr_reg;
            case ({p2_valid_reg, m_pop})
                2'b10:   out_cnt_reg <= out_cnt_reg + 2'd1;
                2'b01:   out_cnt_reg <= out_cnt_reg - 2'd1;
                default: out_cnt_reg <= out_cnt_reg;
            endcase
        end
    end

endmodule
